FILE: rtl/arc_pkg.sv
// ----------------------------------------------------------------------------
// arc_pkg
// Shared types, constants, calibration coefficients and the control store of
// the autorange resistance converter.
// ----------------------------------------------------------------------------
package arc_pkg;

  localparam int SENSOR_COUNT_DEF  = 14;
  localparam int MUX_POSITIONS_DEF = 7;

  localparam int SAMPLE_W   = 10;
  localparam int CHAN_W     = 4;
  localparam int RES_W      = 21;
  localparam int CODE_W     = 2;
  localparam int MUX_W      = 3;
  localparam int STEP_W     = 2;
  localparam int ACC_W      = 48;
  localparam int FRAC_W     = 24;
  localparam int PC_W       = 3;
  localparam int CIDX_W     = 2;

  localparam logic [SAMPLE_W-1:0] CUTOFF_RESET = 10'd150;
  localparam logic [STEP_W-1:0]   STEP_LAST    = 2'd2;

  localparam logic [CODE_W-1:0] CODE_550UA = 2'd0;
  localparam logic [CODE_W-1:0] CODE_55UA  = 2'd3;
  localparam logic [CODE_W-1:0] CODE_5UA5  = 2'd2;

  localparam logic [PC_W-1:0] PC_IDLE = 3'd0;
  localparam logic [PC_W-1:0] PC_LOAD = 3'd1;
  localparam logic [PC_W-1:0] PC_MAC1 = 3'd2;
  localparam logic [PC_W-1:0] PC_MAC2 = 3'd3;
  localparam logic [PC_W-1:0] PC_MAC3 = 3'd4;
  localparam logic [PC_W-1:0] PC_FIN  = 3'd5;

  typedef enum logic [1:0] {
    OP_IDLE,
    OP_LOAD,
    OP_MAC,
    OP_FIN
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [CIDX_W-1:0] cidx;
    logic              br_quad;
    logic [PC_W-1:0]   br_tgt;
  } ucode_t;

  typedef struct packed {
    op_t               op;
    logic [CIDX_W-1:0] cidx;
    logic              idle;
    logic              fin_go;
  } seq_ctl_t;

  function automatic ucode_t ucode(input logic [PC_W-1:0] pc);
    ucode_t w;
    w = '{op: OP_IDLE, cidx: 2'd0, br_quad: 1'b0, br_tgt: PC_IDLE};
    unique case (pc)
      PC_IDLE: w = '{op: OP_IDLE, cidx: 2'd0, br_quad: 1'b0, br_tgt: PC_IDLE};
      PC_LOAD: w = '{op: OP_LOAD, cidx: 2'd0, br_quad: 1'b0, br_tgt: PC_IDLE};
      PC_MAC1: w = '{op: OP_MAC,  cidx: 2'd1, br_quad: 1'b0, br_tgt: PC_IDLE};
      PC_MAC2: w = '{op: OP_MAC,  cidx: 2'd2, br_quad: 1'b1, br_tgt: PC_FIN};
      PC_MAC3: w = '{op: OP_MAC,  cidx: 2'd3, br_quad: 1'b0, br_tgt: PC_IDLE};
      PC_FIN:  w = '{op: OP_FIN,  cidx: 2'd0, br_quad: 1'b0, br_tgt: PC_IDLE};
      default: w = '{op: OP_IDLE, cidx: 2'd0, br_quad: 1'b0, br_tgt: PC_IDLE};
    endcase
    return w;
  endfunction

  // current code sequence per range step
  function automatic logic [CODE_W-1:0] code_seq(input logic [STEP_W-1:0] step);
    logic [CODE_W-1:0] c;
    unique case (step)
      2'd0:    c = CODE_5UA5;
      2'd1:    c = CODE_55UA;
      2'd2:    c = CODE_550UA;
      default: c = CODE_5UA5;
    endcase
    return c;
  endfunction

  // q24 coefficients, highest power first
  function automatic logic signed [ACC_W-1:0] coef(input logic [CODE_W-1:0] code,
                                                    input logic [CIDX_W-1:0] idx);
    logic signed [ACC_W-1:0] c;
    c = '0;
    unique case (code)
      CODE_550UA: begin
        unique case (idx)
          2'd0:    c = 48'sd41943;
          2'd1:    c = 48'sd63451431;
          2'd2:    c = -48'sd14501386650;
          default: c = '0;
        endcase
      end
      CODE_55UA: begin
        unique case (idx)
          2'd0:    c = 48'sd156028;
          2'd1:    c = 48'sd802403910;
          2'd2:    c = 48'sd5064370422;
          default: c = '0;
        endcase
      end
      CODE_5UA5: begin
        unique case (idx)
          2'd0:    c = 48'sd8389;
          2'd1:    c = -48'sd8792939;
          2'd2:    c = 48'sd12022049669;
          default: c = -48'sd105334072934;
        endcase
      end
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

FILE: rtl/arc_seq.sv
// ----------------------------------------------------------------------------
// arc_seq
// Microcode sequencer: program counter over the control store, waits at the
// idle and finish words, skips the cubic term for quadratic ranges.
// ----------------------------------------------------------------------------
module arc_seq (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               cubic,
  input  logic               out_free,
  output arc_pkg::seq_ctl_t  ctl
);

  logic [arc_pkg::PC_W-1:0] pc_r;
  logic [arc_pkg::PC_W-1:0] pc_nxt;
  arc_pkg::ucode_t          word;

  assign word = arc_pkg::ucode(pc_r);

  always_comb begin
    pc_nxt = pc_r;
    unique case (word.op)
      arc_pkg::OP_IDLE: begin
        if (start) pc_nxt = pc_r + 3'd1;
      end
      arc_pkg::OP_FIN: begin
        if (out_free) pc_nxt = arc_pkg::PC_IDLE;
      end
      default: begin
        if (word.br_quad && !cubic) pc_nxt = word.br_tgt;
        else                        pc_nxt = pc_r + 3'd1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= arc_pkg::PC_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

  always_comb begin
    ctl.op     = word.op;
    ctl.cidx   = word.cidx;
    ctl.idle   = (word.op == arc_pkg::OP_IDLE);
    ctl.fin_go = (word.op == arc_pkg::OP_FIN) && out_free;
  end

  pc_legal_a: assert property (@(posedge clk) disable iff (!rst_n)
    pc_r <= arc_pkg::PC_FIN)
    else $error("program counter beyond last word");

  start_load_a: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.idle && start) |=> (pc_r == arc_pkg::PC_LOAD))
    else $error("start did not enter load step");

endmodule

FILE: rtl/arc_dp.sv
// ----------------------------------------------------------------------------
// arc_dp
// Horner datapath: one multiply-accumulate per step on a q24 accumulator,
// then truncation toward zero and saturation to the result width.
// ----------------------------------------------------------------------------
module arc_dp (
  input  logic                               clk,
  input  arc_pkg::seq_ctl_t                  ctl,
  input  logic [arc_pkg::SAMPLE_W-1:0]       sample,
  input  logic [arc_pkg::CODE_W-1:0]         code,
  output logic signed [arc_pkg::RES_W-1:0]   resistance
);

  localparam int SHR_W = arc_pkg::ACC_W - arc_pkg::FRAC_W;
  localparam int PROD_W = arc_pkg::ACC_W + arc_pkg::SAMPLE_W + 1;

  logic signed [arc_pkg::ACC_W-1:0]    acc_r;
  logic signed [arc_pkg::ACC_W-1:0]    acc_nxt;
  logic signed [arc_pkg::ACC_W-1:0]    cf;
  logic signed [arc_pkg::SAMPLE_W:0]   xs;
  logic signed [PROD_W-1:0]            prod;
  logic signed [arc_pkg::ACC_W-1:0]    biased;
  logic signed [SHR_W-1:0]             quot;

  assign cf   = arc_pkg::coef(code, ctl.cidx);
  assign xs   = $signed({1'b0, sample});
  assign prod = acc_r * xs;

  always_comb begin
    acc_nxt = acc_r;
    unique case (ctl.op)
      arc_pkg::OP_LOAD: acc_nxt = cf;
      arc_pkg::OP_MAC:  acc_nxt = $signed(prod[arc_pkg::ACC_W-1:0]) + cf;
      default:          acc_nxt = acc_r;
    endcase
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  // round toward zero on the q24 shift
  assign biased = acc_r[arc_pkg::ACC_W-1]
                ? acc_r + $signed({{SHR_W{1'b0}}, {arc_pkg::FRAC_W{1'b1}}})
                : acc_r;
  assign quot   = biased[arc_pkg::ACC_W-1:arc_pkg::FRAC_W];

  always_comb begin
    if (quot > 24'sd1048575)       resistance = 21'sd1048575;
    else if (quot < -24'sd1048576) resistance = -21'sd1048576;
    else                           resistance = quot[arc_pkg::RES_W-1:0];
  end

endmodule

FILE: rtl/autorange_resistance_converter_top.sv
// ----------------------------------------------------------------------------
// autorange_resistance_converter_top
// Sensor scan and autorange control around a microcoded polynomial unit.
//
//   channel | ports                          | dir | beat
//   --------+--------------------------------+-----+---------------------
//   in      | in_valid, in_stall, in_adc_*   | in  | one adc sample
//   out     | out_valid, out_stall, out_*    | out | one result per sample
//   cfg     | cfg_wr_en, cfg_wr_data         | in  | cutoff threshold
//
// after the accept the unit runs one load step, one multiply-accumulate step
// per further coefficient and a finish step, which loads the result register.
// in_stall is high from accept until the result is loaded, so a new sample is
// not taken before the result of the last one is loaded.
// the result register holds while out_stall is high and the finish step waits
// for it. synchronous reset clears the scan state, cutoff is 150.
// ----------------------------------------------------------------------------
module autorange_resistance_converter_top #(
  parameter int SENSOR_COUNT  = arc_pkg::SENSOR_COUNT_DEF,
  parameter int MUX_POSITIONS = arc_pkg::MUX_POSITIONS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [arc_pkg::SAMPLE_W-1:0]      cfg_wr_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [arc_pkg::SAMPLE_W-1:0]      in_adc_sample,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_result_valid,
  output logic [arc_pkg::CHAN_W-1:0]        out_result_channel,
  output logic signed [arc_pkg::RES_W-1:0]  out_resistance,
  output logic [arc_pkg::CODE_W-1:0]        out_range_code,
  output logic [arc_pkg::MUX_W-1:0]         out_next_mux_select,
  output logic                              out_next_adc_input,
  output logic [arc_pkg::CODE_W-1:0]        out_next_current_code
);

  logic [arc_pkg::SAMPLE_W-1:0] cutoff_r;
  logic [arc_pkg::CHAN_W-1:0]   sensor_r;
  logic [arc_pkg::MUX_W-1:0]    mux_r;
  logic                         bank_r;
  logic [arc_pkg::STEP_W-1:0]   range_step_r;

  logic [arc_pkg::SAMPLE_W-1:0] sample_r;
  logic [arc_pkg::CODE_W-1:0]   code_r;
  logic                         done_r;
  logic [arc_pkg::CHAN_W-1:0]   chan_r;

  logic                         out_valid_r;
  logic                         res_valid_r;
  logic [arc_pkg::CHAN_W-1:0]   res_chan_r;
  logic signed [arc_pkg::RES_W-1:0] res_r;
  logic [arc_pkg::CODE_W-1:0]   res_code_r;
  logic [arc_pkg::MUX_W-1:0]    nmux_r;
  logic                         nbank_r;
  logic [arc_pkg::CODE_W-1:0]   ncode_r;

  logic                         accept;
  logic                         out_free;
  logic [arc_pkg::STEP_W-1:0]   step;
  logic [arc_pkg::CODE_W-1:0]   code;
  logic                         done;
  logic                         sensor_wrap;
  logic                         mux_wrap;
  logic signed [arc_pkg::RES_W-1:0] dp_res;
  arc_pkg::seq_ctl_t            ctl;

  assign in_stall = !ctl.idle;
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  assign step = (range_step_r <= arc_pkg::STEP_LAST) ? range_step_r : '0;
  assign code = arc_pkg::code_seq(step);
  assign done = (in_adc_sample > cutoff_r) || (step == arc_pkg::STEP_LAST);

  assign sensor_wrap = ({1'b0, sensor_r} + 5'd1) >= 5'(SENSOR_COUNT);
  assign mux_wrap    = ({1'b0, mux_r} + 4'd1) == 4'(MUX_POSITIONS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cutoff_r <= arc_pkg::CUTOFF_RESET;
    end else if (cfg_wr_en) begin
      cutoff_r <= cfg_wr_data;
    end
  end

  // scan position and range step
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sensor_r     <= '0;
      mux_r        <= '0;
      bank_r       <= 1'b0;
      range_step_r <= '0;
    end else if (accept) begin
      if (done) begin
        range_step_r <= '0;
        if (sensor_wrap) begin
          sensor_r <= '0;
          mux_r    <= '0;
          bank_r   <= 1'b0;
        end else begin
          sensor_r <= sensor_r + 4'd1;
          if (mux_wrap) begin
            mux_r  <= '0;
            bank_r <= !bank_r;
          end else begin
            mux_r  <= mux_r + 3'd1;
          end
        end
      end else begin
        range_step_r <= step + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sample_r <= in_adc_sample;
      code_r   <= code;
      done_r   <= done;
      chan_r   <= sensor_r;
    end
  end

  arc_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (accept),
    .cubic    (code_r == arc_pkg::CODE_5UA5),
    .out_free (out_free),
    .ctl      (ctl)
  );

  arc_dp u_dp (
    .clk        (clk),
    .ctl        (ctl),
    .sample     (sample_r),
    .code       (code_r),
    .resistance (dp_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.fin_go) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.fin_go) begin
      res_valid_r <= done_r;
      res_chan_r  <= done_r ? chan_r : '0;
      res_r       <= done_r ? dp_res : '0;
      res_code_r  <= done_r ? code_r : '0;
      nmux_r      <= mux_r;
      nbank_r     <= bank_r;
      ncode_r     <= arc_pkg::code_seq(range_step_r);
    end
  end

  assign out_valid             = out_valid_r;
  assign out_result_valid      = res_valid_r;
  assign out_result_channel    = res_chan_r;
  assign out_resistance        = res_r;
  assign out_range_code        = res_code_r;
  assign out_next_mux_select   = nmux_r;
  assign out_next_adc_input    = nbank_r;
  assign out_next_current_code = ncode_r;

  accept_blocks_a: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> in_stall)
    else $error("input taken while unit busy");

  step_legal_a: assert property (@(posedge clk) disable iff (!rst_n)
    range_step_r <= arc_pkg::STEP_LAST)
    else $error("range step beyond last code");

  sensor_legal_a: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, sensor_r} < 5'(SENSOR_COUNT))
    else $error("sensor index beyond sensor count");

  idle_result_zero_a: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_result_valid) |->
      (out_resistance == '0 && out_result_channel == '0 && out_range_code == '0))
    else $error("incomplete sensor beat carries result data");

endmodule
